// File: design/pbpm_pkg.sv
// shared types, codes and defaults for the page buffer pool manager
// no dependencies; imported by pbpm_ctrl, pbpm_dp and the top level
package pbpm_pkg;

    localparam int NUM_FRAMES_DEF   = 32;
    localparam int PAGE_ID_BITS_DEF = 32;
    localparam int PIN_BITS_DEF     = 16;

    typedef enum logic [1:0] {
        OP_ACCESS = 2'd0,
        OP_UNPIN  = 2'd1,
        OP_DIRTY  = 2'd2,
        OP_FLUSH  = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_NOT_RESIDENT = 2'd1;
    localparam logic [1:0] ST_ALL_PINNED   = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DECIDE,
        S_ROT_Q,
        S_ROT_F,
        S_ROT_CHK,
        S_EVICT,
        S_FULL
    } state_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_PIN,
        WR_FILL_EMPTY,
        WR_FILL_VICTIM,
        WR_UNPIN,
        WR_DIRTY
    } wr_t;

    typedef enum logic [3:0] {
        RES_NONE,
        RES_HIT,
        RES_FILL,
        RES_EVICT,
        RES_NOT_RES,
        RES_ALL_PINNED,
        RES_OK_MATCH,
        RES_FLUSH_PEND,
        RES_FLUSH_LAST,
        RES_FLUSH_NONE
    } res_t;

    typedef struct packed {
        logic capture;
        logic idx_inc;
        logic scan_rd;
        logic scan_chk;
        logic q_rd;
        logic victim_rd;
        logic rot_adv;
        logic rot_clr;
        logic q_push;
        logic pend_load;
        wr_t  fr_wr;
        res_t res;
    } pbpm_cmd_t;

    typedef struct packed {
        op_t  op;
        logic page_reserved;
        logic idx_last;
        logic match_found;
        logic empty_found;
        logic rec_dirty_valid;
        logic rec_pins_zero;
        logic rot_last;
        logic out_free;
        logic pend_valid;
    } pbpm_sts_t;

endpackage

// File: design/pbpm_ram.sv
// generic single write, single read ram with registered read data
// depends on nothing
module pbpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/pbpm_ctrl.sv
// sequencing state machine of the page buffer pool manager
// depends on pbpm_pkg; drives the datapath through pbpm_cmd_t
module pbpm_ctrl
    import pbpm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  pbpm_sts_t sts,
    output logic      in_ready,
    output pbpm_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // flush must emit the held result before taking a new dirty frame
    logic flush_stall;
    assign flush_stall = (sts.op == OP_FLUSH) && sts.rec_dirty_valid && sts.pend_valid
                         && !sts.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.idx_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (!flush_stall)
                begin
                    state_next = sts.idx_last ? S_DECIDE : S_SCAN_RD;
                end
            end
            S_DECIDE:
            begin
                if (sts.out_free)
                begin
                    if (sts.op == OP_ACCESS && !sts.page_reserved && !sts.match_found
                        && !sts.empty_found)
                    begin
                        state_next = S_ROT_Q;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ROT_Q:
            begin
                state_next = S_ROT_F;
            end
            S_ROT_F:
            begin
                state_next = S_ROT_CHK;
            end
            S_ROT_CHK:
            begin
                if (sts.rec_pins_zero)
                begin
                    state_next = S_EVICT;
                end
                else if (sts.rot_last)
                begin
                    state_next = S_FULL;
                end
                else
                begin
                    state_next = S_ROT_Q;
                end
            end
            S_EVICT, S_FULL:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.fr_wr = WR_NONE;
        cmd.res   = RES_NONE;
        in_ready  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.fr_wr   = WR_CLEAR;
                cmd.idx_inc = 1'b1;
            end
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
            end
            S_SCAN_CHK:
            begin
                if (!flush_stall)
                begin
                    cmd.scan_chk = 1'b1;
                    cmd.idx_inc  = 1'b1;
                    if (sts.op == OP_FLUSH && sts.rec_dirty_valid)
                    begin
                        cmd.pend_load = 1'b1;
                        if (sts.pend_valid)
                        begin
                            cmd.res = RES_FLUSH_PEND;
                        end
                    end
                end
            end
            S_DECIDE:
            begin
                if (sts.out_free)
                begin
                    priority if (sts.op == OP_FLUSH)
                    begin
                        cmd.res = sts.pend_valid ? RES_FLUSH_LAST : RES_FLUSH_NONE;
                    end
                    else if (sts.page_reserved)
                    begin
                        cmd.res = RES_NOT_RES;
                    end
                    else if (sts.op == OP_ACCESS)
                    begin
                        priority if (sts.match_found)
                        begin
                            cmd.fr_wr = WR_PIN;
                            cmd.res   = RES_HIT;
                        end
                        else if (sts.empty_found)
                        begin
                            cmd.fr_wr  = WR_FILL_EMPTY;
                            cmd.q_push = 1'b1;
                            cmd.res    = RES_FILL;
                        end
                        else
                        begin
                            cmd.rot_clr = 1'b1;
                        end
                    end
                    else if (sts.match_found)
                    begin
                        cmd.fr_wr = (sts.op == OP_UNPIN) ? WR_UNPIN : WR_DIRTY;
                        cmd.res   = RES_OK_MATCH;
                    end
                    else
                    begin
                        cmd.res = RES_NOT_RES;
                    end
                end
            end
            S_ROT_Q:
            begin
                cmd.q_rd = 1'b1;
            end
            S_ROT_F:
            begin
                cmd.victim_rd = 1'b1;
            end
            S_ROT_CHK:
            begin
                cmd.rot_adv = 1'b1;
            end
            S_EVICT:
            begin
                if (sts.out_free)
                begin
                    cmd.fr_wr = WR_FILL_VICTIM;
                    cmd.res   = RES_EVICT;
                end
            end
            S_FULL:
            begin
                if (sts.out_free)
                begin
                    cmd.res = RES_ALL_PINNED;
                end
            end
            default:
            begin
                cmd.res = RES_NONE;
            end
        endcase
    end

endmodule

// File: design/pbpm_dp.sv
// frame table, victim queue, scan registers and result register
// depends on pbpm_pkg and pbpm_ram; commanded by pbpm_ctrl
module pbpm_dp
    import pbpm_pkg::*;
#(
    parameter int NUM_FRAMES   = NUM_FRAMES_DEF,
    parameter int PAGE_ID_BITS = PAGE_ID_BITS_DEF,
    parameter int PIN_BITS     = PIN_BITS_DEF,
    localparam int FB    = $clog2(NUM_FRAMES),
    localparam int IN_W  = ((PAGE_ID_BITS + 2 + 7) / 8) * 8,
    localparam int OUT_W = ((PAGE_ID_BITS + FB + 7 + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pbpm_cmd_t        cmd,
    output pbpm_sts_t        sts,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic [1:0]       s_tuser,
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast
);

    localparam int P   = PAGE_ID_BITS;
    localparam int REC = P + PIN_BITS + 3;
    localparam logic [P-1:0]  EMPTY    = '1;
    localparam logic [FB-1:0] LAST_IDX = FB'(NUM_FRAMES - 1);

    // captured request
    op_t          op_reg;
    logic [P-1:0] page_reg;
    logic [1:0]   kind_reg;

    // scan state
    logic [FB-1:0]  idx_reg;
    logic           match_found_reg, empty_found_reg, pend_valid_reg;
    logic [FB-1:0]  match_idx_reg, empty_idx_reg, pend_idx_reg;
    logic [REC-1:0] match_rec_reg;
    logic [P-1:0]   pend_page_reg;
    logic [1:0]     pend_kind_reg;

    // victim queue pointers
    logic [FB-1:0] head_reg, rot_cnt_reg, v_reg;
    logic [FB:0]   count_reg;

    // result register
    logic          out_valid_reg;
    logic [1:0]    o_status_reg, o_kind_reg;
    logic          o_hit_reg, o_fetch_reg, o_wb_reg, o_last_reg;
    logic [FB-1:0] o_frame_reg;
    logic [P-1:0]  o_page_reg;

    // frame table ram: {kind, dirty, pins, page}
    logic           fr_wr_en, fr_rd_en;
    logic [FB-1:0]  fr_wr_addr, fr_rd_addr;
    logic [REC-1:0] fr_wr_data, fr_rd_data;

    logic [FB-1:0] q_rd_data, q_tail;
    logic [FB:0]   tail_sum;

    logic [P-1:0]        rec_page;
    logic [PIN_BITS-1:0] rec_pins, m_pins;
    logic                rec_dirty;
    logic [1:0]          rec_kind;

    assign rec_page  = fr_rd_data[P-1:0];
    assign rec_pins  = fr_rd_data[P+PIN_BITS-1:P];
    assign rec_dirty = fr_rd_data[P+PIN_BITS];
    assign rec_kind  = fr_rd_data[P+PIN_BITS+2:P+PIN_BITS+1];
    assign m_pins    = match_rec_reg[P+PIN_BITS-1:P];

    assign tail_sum = {1'b0, head_reg} + count_reg;
    assign q_tail   = (tail_sum >= (FB+1)'(NUM_FRAMES)) ?
                      FB'(tail_sum - (FB+1)'(NUM_FRAMES)) : tail_sum[FB-1:0];

    assign fr_rd_en   = cmd.scan_rd | cmd.victim_rd;
    assign fr_rd_addr = cmd.victim_rd ? q_rd_data : idx_reg;
    assign fr_wr_en   = (cmd.fr_wr != WR_NONE);

    always_comb
    begin
        fr_wr_addr = idx_reg;
        fr_wr_data = {2'b00, 1'b0, {PIN_BITS{1'b0}}, EMPTY};
        unique case (cmd.fr_wr)
            WR_NONE, WR_CLEAR:
            begin
                fr_wr_addr = idx_reg;
            end
            WR_PIN:
            begin
                fr_wr_addr = match_idx_reg;
                fr_wr_data = match_rec_reg;
                fr_wr_data[P+PIN_BITS-1:P] = (m_pins == '1) ? m_pins : m_pins + 1'b1;
            end
            WR_FILL_EMPTY:
            begin
                fr_wr_addr = empty_idx_reg;
                fr_wr_data = {kind_reg, 1'b0, PIN_BITS'(1), page_reg};
            end
            WR_FILL_VICTIM:
            begin
                fr_wr_addr = v_reg;
                fr_wr_data = {kind_reg, 1'b0, PIN_BITS'(1), page_reg};
            end
            WR_UNPIN:
            begin
                fr_wr_addr = match_idx_reg;
                fr_wr_data = match_rec_reg;
                fr_wr_data[P+PIN_BITS-1:P] = (m_pins == '0) ? m_pins : m_pins - 1'b1;
            end
            WR_DIRTY:
            begin
                fr_wr_addr = match_idx_reg;
                fr_wr_data = match_rec_reg;
                fr_wr_data[P+PIN_BITS] = 1'b1;
            end
            default:
            begin
                fr_wr_addr = idx_reg;
            end
        endcase
    end

    pbpm_ram #(.WIDTH(REC), .DEPTH(NUM_FRAMES)) u_frame_ram (
        .clk     (clk),
        .wr_en   (fr_wr_en),
        .wr_addr (fr_wr_addr),
        .wr_data (fr_wr_data),
        .rd_en   (fr_rd_en),
        .rd_addr (fr_rd_addr),
        .rd_data (fr_rd_data)
    );

    pbpm_ram #(.WIDTH(FB), .DEPTH(NUM_FRAMES)) u_queue_ram (
        .clk     (clk),
        .wr_en   (cmd.q_push),
        .wr_addr (q_tail),
        .wr_data (empty_idx_reg),
        .rd_en   (cmd.q_rd),
        .rd_addr (head_reg),
        .rd_data (q_rd_data)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg         <= '0;
            head_reg        <= '0;
            count_reg       <= '0;
            rot_cnt_reg     <= '0;
            match_found_reg <= 1'b0;
            empty_found_reg <= 1'b0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.idx_inc)
            begin
                idx_reg <= (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
            end
            if (cmd.capture)
            begin
                match_found_reg <= 1'b0;
                empty_found_reg <= 1'b0;
                pend_valid_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.scan_chk && rec_page == page_reg)
                begin
                    match_found_reg <= 1'b1;
                end
                if (cmd.scan_chk && rec_page == EMPTY)
                begin
                    empty_found_reg <= 1'b1;
                end
                if (cmd.pend_load)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
            if (cmd.q_push)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.rot_clr)
            begin
                rot_cnt_reg <= '0;
            end
            else if (cmd.rot_adv)
            begin
                rot_cnt_reg <= rot_cnt_reg + 1'b1;
                head_reg    <= (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
            end
            if (cmd.res != RES_NONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op_t'(s_tuser);
            page_reg <= s_tdata[P-1:0];
            kind_reg <= s_tdata[P+1:P];
        end
        if (cmd.scan_chk && !match_found_reg && rec_page == page_reg)
        begin
            match_idx_reg <= idx_reg;
            match_rec_reg <= fr_rd_data;
        end
        if (cmd.scan_chk && !empty_found_reg && rec_page == EMPTY)
        begin
            empty_idx_reg <= idx_reg;
        end
        if (cmd.pend_load)
        begin
            pend_idx_reg  <= idx_reg;
            pend_page_reg <= rec_page;
            pend_kind_reg <= rec_kind;
        end
        if (cmd.victim_rd)
        begin
            v_reg <= q_rd_data;
        end
        if (cmd.res != RES_NONE)
        begin
            o_status_reg <= ST_OK;
            o_hit_reg    <= 1'b0;
            o_frame_reg  <= '0;
            o_fetch_reg  <= 1'b0;
            o_wb_reg     <= 1'b0;
            o_page_reg   <= '0;
            o_kind_reg   <= 2'b00;
            o_last_reg   <= 1'b1;
            unique case (cmd.res)
                RES_HIT:
                begin
                    o_hit_reg   <= 1'b1;
                    o_frame_reg <= match_idx_reg;
                end
                RES_FILL:
                begin
                    o_frame_reg <= empty_idx_reg;
                    o_fetch_reg <= 1'b1;
                end
                RES_EVICT:
                begin
                    o_frame_reg <= v_reg;
                    o_fetch_reg <= 1'b1;
                    o_wb_reg    <= rec_dirty;
                    o_page_reg  <= rec_dirty ? rec_page : '0;
                    o_kind_reg  <= rec_dirty ? rec_kind : 2'b00;
                end
                RES_NOT_RES:
                begin
                    o_status_reg <= ST_NOT_RESIDENT;
                end
                RES_ALL_PINNED:
                begin
                    o_status_reg <= ST_ALL_PINNED;
                end
                RES_OK_MATCH:
                begin
                    o_frame_reg <= match_idx_reg;
                end
                RES_FLUSH_PEND, RES_FLUSH_LAST:
                begin
                    o_frame_reg <= pend_idx_reg;
                    o_wb_reg    <= 1'b1;
                    o_page_reg  <= pend_page_reg;
                    o_kind_reg  <= pend_kind_reg;
                    o_last_reg  <= (cmd.res == RES_FLUSH_LAST);
                end
                default:
                begin
                    o_last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = OUT_W'({o_kind_reg, o_page_reg, o_wb_reg, o_fetch_reg, o_frame_reg,
                              o_hit_reg, o_status_reg});

    assign sts.op              = op_reg;
    assign sts.page_reserved   = (page_reg == EMPTY);
    assign sts.idx_last        = (idx_reg == LAST_IDX);
    assign sts.match_found     = match_found_reg;
    assign sts.empty_found     = empty_found_reg;
    assign sts.rec_dirty_valid = rec_dirty && (rec_page != EMPTY);
    assign sts.rec_pins_zero   = (rec_pins == '0);
    assign sts.rot_last        = (rot_cnt_reg == LAST_IDX);
    assign sts.out_free        = !out_valid_reg || m_tready;
    assign sts.pend_valid      = pend_valid_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FB+1)'(NUM_FRAMES))
        else $error("victim queue count above frame count");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= LAST_IDX)
        else $error("queue head out of range");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.q_push |-> count_reg < (FB+1)'(NUM_FRAMES))
        else $error("queue push with full queue");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res != RES_NONE) |-> (!out_valid_reg || m_tready))
        else $error("result loaded over a result not yet taken");

endmodule

// File: design/page_buffer_pool_manager_unit.sv
// top level of the page buffer pool manager
// depends on pbpm_pkg, pbpm_ctrl and pbpm_dp (which holds two pbpm_ram instances)
//
// usage
// - input channel s_*: one transfer is one request; s_tuser carries the operation
//   (access and pin, unpin, mark dirty, flush dirty frames), s_tdata the page number
//   and the page kind
// - output channel m_*: one or more result transfers per request; m_tlast marks the
//   final result of a request (a flush: one result per dirty frame, at least one)
// - the block takes one request at a time; s_tready is high only while no request
//   is in work, but a finished result may still wait in the output register
// - order of work: every request scans the frame table, reading then checking each
//   frame in turn; an access that finds neither the page nor an empty frame then walks
//   the victim queue, reading a queue entry, then its frame, then checking its pins;
//   the frame table ram has a single read port, so frames are read one at a time
// - after reset a clearing pass marks every frame empty, with s_tready low
// - a stalled receiver holds the result register; the sequencer waits at the next
//   result it has to emit, so nothing is dropped
module page_buffer_pool_manager_unit
    import pbpm_pkg::*;
#(
    parameter int NUM_FRAMES   = NUM_FRAMES_DEF,
    parameter int PAGE_ID_BITS = PAGE_ID_BITS_DEF,
    parameter int PIN_BITS     = PIN_BITS_DEF,
    localparam int FB    = $clog2(NUM_FRAMES),
    localparam int IN_W  = ((PAGE_ID_BITS + 2 + 7) / 8) * 8,
    localparam int OUT_W = ((PAGE_ID_BITS + FB + 7 + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // page_number, page_kind, zero fill
    input  logic [IN_W-1:0]  s_tdata,
    // operation
    input  logic [1:0]       s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // status, hit, frame_index, fetch_needed, writeback_needed, writeback_page,
    // writeback_kind, zero fill
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast
);

    pbpm_cmd_t cmd;
    pbpm_sts_t sts;

    // sequencer: one request at a time, scan then decide then optional queue walk
    pbpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .sts      (sts),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    // frame table, victim queue and result register
    pbpm_dp #(
        .NUM_FRAMES   (NUM_FRAMES),
        .PAGE_ID_BITS (PAGE_ID_BITS),
        .PIN_BITS     (PIN_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
